/* design/row_chunk_write_descriptor_gen_defines.svh */
// Assertion macros used by the descriptor generator back end.
`ifndef ROW_CHUNK_WRITE_DESCRIPTOR_GEN_DEFINES_SVH
`define ROW_CHUNK_WRITE_DESCRIPTOR_GEN_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define RCWD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcwd: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define RCWD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcwd: next-cycle check failed");

`endif

/* design/rcwd_pkg.sv */
// Types and constants shared by the row chunk write descriptor generator.
package rcwd_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DIVISOR_W   = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_PAGES_PER_ROW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ELEMENTS_PER_PAGE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_ELEM    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ELEMENTS_PER_ROW  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SUBBLOCK_BYTES    = 3'd4;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_NEXT    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_IDLE = 1'b1;

	typedef struct packed {
		logic        command;
		logic [19:0] first_row;
		logic [20:0] row_count;
	} request_t;

	typedef struct packed {
		logic        status;
		logic [31:0] page_id;
		logic [23:0] byte_offset;
		logic [15:0] byte_count;
		logic        row_done;
		logic        job_done;
	} result_t;

	// Configuration as seen by the back end, zero values already forced to one
	// where the register is used as a divisor or a limit.
	typedef struct packed {
		logic [15:0] pages_per_row;
		logic [15:0] elements_per_page;
		logic [6:0]  bytes_per_elem;
		logic [15:0] elements_per_row;
		logic [15:0] subblock_bytes;
	} cfg_t;

	typedef enum logic {
		KIND_START,
		KIND_NEXT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [19:0] first_row;
		logic [20:0] row_count;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} queue_head_t;

endpackage

/* design/rcwd_front.sv */
// Front end: takes requests, classifies them and holds them in a two-entry queue.
module rcwd_front
	import rcwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  request_t    request,
	output queue_head_t head,
	input  logic        pop
);

	entry_t     entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	entry_t     new_entry;

	assign busy = (count_q == 2'd2);
	assign push = start && !busy;

	always_comb begin
		new_entry.kind      = (request.command == CMD_NEXT) ? KIND_NEXT : KIND_START;
		new_entry.first_row = request.first_row;
		new_entry.row_count = request.row_count;
	end

	assign head.valid = (count_q != 2'd0);
	assign head.entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/rcwd_div.sv */
// Restoring divider that retires two quotient bits per cycle.
module rcwd_div
	import rcwd_pkg::*;
#(
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [DW-1:0]        dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output logic [DW-1:0]        quotient,
	output logic [DIVISOR_W-1:0] remainder
);

	localparam int DWE  = DW + (DW % 2);
	localparam int ITER = DWE / 2;
	localparam int CNTW = $clog2(ITER + 1);

	logic [DIVISOR_W:0]   rem_q;
	logic [DWE-1:0]       quo_q;
	logic [DIVISOR_W-1:0] dvs_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIVISOR_W:0]   rem_d;
	logic [DWE-1:0]       quo_d;

	// Two dependent shift-and-subtract steps per cycle.
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < 2; i++) begin
			rem_d = {rem_d[DIVISOR_W-1:0], quo_d[DWE-1]};
			quo_d = {quo_d[DWE-2:0], 1'b0};
			if (rem_d >= {1'b0, dvs_q}) begin
				rem_d    = rem_d - {1'b0, dvs_q};
				quo_d[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= DWE'(dividend);
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNTW'(ITER);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q[DW-1:0];
	assign remainder = rem_q[DIVISOR_W-1:0];

endmodule

/* design/rcwd_back.sv */
// Back end: holds the job state; a next request yields a descriptor, or idle status.
module rcwd_back
	import rcwd_pkg::*;
#(
	parameter int ROW_WIDTH    = 20,
	parameter int COLUMN_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  queue_head_t head,
	output logic        pop,
	output logic        result_valid,
	output result_t     result
);

	`include "row_chunk_write_descriptor_gen_defines.svh"

	localparam int DW = (COLUMN_WIDTH > 16) ? COLUMN_WIDTH : 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EPS,
		ST_COL,
		ST_POS,
		ST_MUL,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [ROW_WIDTH-1:0]    row_q;
	logic [20:0]             rows_left_q;
	logic [COLUMN_WIDTH-1:0] col_q;
	logic                    active_q;
	logic                    result_valid_q;
	result_t                 result_q;

	logic                 div_go_q;
	logic [DW-1:0]        div_a_q;
	logic [DIVISOR_W-1:0] div_b_q;
	logic                 div_done;
	logic [DW-1:0]        div_quo;
	logic [DIVISOR_W-1:0] div_rem;

	logic [15:0] eps_q;
	logic [DW-1:0] colq_q;
	logic [15:0] sbi_q;
	logic [15:0] len_q;
	logic        in_row_q;
	logic [31:0] rowprod_q;
	logic [23:0] off_q;
	logic [15:0] cnt_q;

	logic [DW-1:0]          col_ext;
	logic [DW-1:0]          epr_ext;
	logic                   in_row;
	logic [15:0]            row_room;
	logic [15:0]            page_room;
	logic [15:0]            len_next;
	logic [15:0]            eps_next;
	logic [DW:0]            col_sum;
	logic                   row_done_w;
	logic [20:0]            rows_left_dec;
	logic [ROW_WIDTH+15:0]  rowprod_w;
	logic [31:0]            offprod;
	logic [22:0]            cntprod;
	logic [31:0]            page_sum;

	rcwd_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_comb begin
		col_ext   = DW'(col_q);
		epr_ext   = DW'(cfg.elements_per_row);
		in_row    = (col_ext < epr_ext);
		row_room  = 16'(epr_ext - col_ext);
		page_room = cfg.elements_per_page - div_rem;
		// Chunk length: least of subblock size, room left in row, room left in page.
		len_next  = eps_q;
		if (row_room < len_next) begin
			len_next = row_room;
		end
		if (page_room < len_next) begin
			len_next = page_room;
		end
		eps_next      = (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
		col_sum       = (DW+1)'(col_q) + (DW+1)'(len_q);
		row_done_w    = !in_row_q || (col_sum >= (DW+1)'(cfg.elements_per_row));
		rows_left_dec = rows_left_q - 21'd1;
		rowprod_w     = row_q * cfg.pages_per_row;
		offprod       = sbi_q * cfg.subblock_bytes;
		cntprod       = len_q * cfg.bytes_per_elem;
		page_sum      = rowprod_q + 32'(colq_q);
	end

	assign pop = (state_q == ST_IDLE) && head.valid;

	// Datapath registers: divider operands and per-chunk intermediate values.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				div_a_q <= DW'(cfg.subblock_bytes);
				div_b_q <= DIVISOR_W'(cfg.bytes_per_elem);
			end
			ST_EPS: begin
				if (div_done) begin
					eps_q   <= eps_next;
					div_a_q <= col_ext;
					div_b_q <= cfg.elements_per_page;
				end
			end
			ST_COL: begin
				if (div_done) begin
					colq_q   <= div_quo;
					in_row_q <= in_row;
					len_q    <= len_next;
					div_a_q  <= DW'(div_rem);
					div_b_q  <= eps_q;
				end
			end
			ST_POS: begin
				if (div_done) begin
					sbi_q <= div_quo[15:0];
				end
			end
			ST_MUL: begin
				rowprod_q <= 32'(rowprod_w);
				off_q     <= offprod[23:0];
				cnt_q     <= cntprod[15:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_q          <= '0;
			rows_left_q    <= '0;
			col_q          <= '0;
			active_q       <= 1'b0;
			div_go_q       <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			div_go_q       <= 1'b0;
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (head.entry.kind == KIND_START) begin
							row_q       <= ROW_WIDTH'(head.entry.first_row);
							rows_left_q <= head.entry.row_count;
							col_q       <= '0;
							active_q    <= (head.entry.row_count != 21'd0);
						end else if (!active_q) begin
							result_q.status      <= STATUS_IDLE;
							result_q.page_id     <= '0;
							result_q.byte_offset <= '0;
							result_q.byte_count  <= '0;
							result_q.row_done    <= 1'b0;
							result_q.job_done    <= 1'b0;
							result_valid_q       <= 1'b1;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= ST_EPS;
						end
					end
				end
				ST_EPS: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_COL;
					end
				end
				ST_COL: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_POS;
					end
				end
				ST_POS: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					result_q.status      <= STATUS_OK;
					result_q.page_id     <= page_sum;
					result_q.byte_offset <= off_q;
					result_q.byte_count  <= in_row_q ? cnt_q : 16'd0;
					result_q.row_done    <= row_done_w;
					result_q.job_done    <= row_done_w && (rows_left_dec == 21'd0);
					result_valid_q       <= 1'b1;
					if (row_done_w) begin
						col_q       <= '0;
						row_q       <= row_q + ROW_WIDTH'(1);
						rows_left_q <= rows_left_dec;
						if (rows_left_dec == 21'd0) begin
							active_q <= 1'b0;
						end
					end else begin
						col_q <= COLUMN_WIDTH'(col_sum);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`RCWD_ASSERT_NEXT(a_fin_emits, state_q == ST_FIN, result_valid_q)
	`RCWD_ASSERT_NOW(a_job_ends_row, result_valid_q && result_q.job_done, result_q.row_done)
	`RCWD_ASSERT_NOW(a_idle_is_empty, result_valid_q && result_q.status == STATUS_IDLE, (result_q.byte_count == 16'd0) && (result_q.page_id == 32'd0) && !result_q.row_done)
	`RCWD_ASSERT_NOW(a_job_done_clears, result_valid_q && result_q.job_done, !active_q)

endmodule

/* design/row_chunk_write_descriptor_gen.sv */
// Top level of the row chunk write descriptor generator.
//
// A request is taken at a rising edge where start is high and busy is low. A start
// request (command 0) loads the first row and row count of a job and yields no
// result. A next request (command 1) yields exactly one result, shown on result
// for a single cycle while result_valid is high; the receiver cannot hold it off,
// so it must sample it then. When no job is active a next request returns status 1
// with all other fields zero, in the cycle right after the edge at which it leaves
// the queue. Otherwise one shared divider that retires two quotient bits per cycle
// runs three times per descriptor (elements per subblock, page and in-page position
// of the column, subblock index), followed by a multiply state (ST_MUL) and a
// finishing state (ST_FIN). Up to two requests wait in a queue in front of the
// sequencer, so busy only rises when both slots are taken. Configuration registers
// are written through cfg_we, cfg_index and cfg_wdata at any edge with cfg_we high,
// and must only change while no descriptor is in work.

module row_chunk_write_descriptor_gen
	import rcwd_pkg::*;
#(
	parameter int ROW_WIDTH    = 20,
	parameter int COLUMN_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  request_t               request,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output logic                   result_valid,
	output result_t                result
);

	logic [15:0] pages_per_row_q;
	logic [15:0] elements_per_page_q;
	logic [6:0]  bytes_per_elem_q;
	logic [15:0] elements_per_row_q;
	logic [15:0] subblock_bytes_q;

	cfg_t        cfg;
	queue_head_t head;
	logic        pop;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_per_row_q     <= 16'd1;
			elements_per_page_q <= 16'd1;
			bytes_per_elem_q    <= 7'd1;
			elements_per_row_q  <= 16'd1;
			subblock_bytes_q    <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAGES_PER_ROW:     pages_per_row_q     <= cfg_wdata;
				REG_ELEMENTS_PER_PAGE: elements_per_page_q <= cfg_wdata;
				REG_BYTES_PER_ELEM:    bytes_per_elem_q    <= cfg_wdata[6:0];
				REG_ELEMENTS_PER_ROW:  elements_per_row_q  <= cfg_wdata;
				REG_SUBBLOCK_BYTES:    subblock_bytes_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Element size, page size and row length of zero behave as one. Pages per row
	// and subblock bytes are used as written.
	always_comb begin
		cfg.pages_per_row     = pages_per_row_q;
		cfg.elements_per_page = (elements_per_page_q == 16'd0) ? 16'd1 : elements_per_page_q;
		cfg.bytes_per_elem    = (bytes_per_elem_q == 7'd0) ? 7'd1 : bytes_per_elem_q;
		cfg.elements_per_row  = (elements_per_row_q == 16'd0) ? 16'd1 : elements_per_row_q;
		cfg.subblock_bytes    = subblock_bytes_q;
	end

	// Request intake and queue.
	rcwd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.head   (head),
		.pop    (pop)
	);

	// Job state and descriptor sequencer.
	rcwd_back #(
		.ROW_WIDTH   (ROW_WIDTH),
		.COLUMN_WIDTH(COLUMN_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
